// ===== src/cylinder_surface_point_macros.svh =====
// Assertion helpers for the cylinder surface point block.
`ifndef CYLINDER_SURFACE_POINT_MACROS_SVH
`define CYLINDER_SURFACE_POINT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CSP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define CSP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/csp_pkg.sv =====
`timescale 1ns / 1ps
package csp_pkg;

   localparam int CSP_CORDIC_STAGES = 16;
   localparam int CSP_ATAN_ENTRIES  = 24;
   localparam int CSP_FIFO_DEPTH    = 4;
   localparam int CSP_XW            = 34;

   localparam logic signed [CSP_XW-1:0] CSP_CORDIC_K = 34'sd652032875;

   // Arctangent table, phase units of 2^32 per turn
   localparam logic signed [CSP_XW-1:0] CSP_ATAN [0:CSP_ATAN_ENTRIES-1] = '{
      34'sd536870912, 34'sd316933405, 34'sd167458907, 34'sd85004756,
      34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
      34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
      34'sd166886,    34'sd83443,     34'sd41721,     34'sd20861,
      34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
      34'sd652,       34'sd326,       34'sd163,       34'sd81
   };

   typedef enum logic [2:0] {
      CSR_CENTER_X     = 3'd0,
      CSR_CENTER_Y     = 3'd1,
      CSR_CENTER_Z     = 3'd2,
      CSR_RADIUS       = 3'd3,
      CSR_AXIAL_LENGTH = 3'd4,
      CSR_ROT_COS      = 3'd5,
      CSR_ROT_SIN      = 3'd6,
      CSR_AXIS_MODE    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic        [15:0] angle_turns;
      logic signed [15:0] axial_position;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] center_z;
      logic        [30:0] radius;
      logic        [30:0] axial_length;
      logic signed [15:0] rot_cos;
      logic signed [15:0] rot_sin;
      logic               axis_mode;
   } cfg_type;

   // Classified request: reduced phase, half-turn flag, axial parameter
   typedef struct packed {
      logic signed [31:0] phase;
      logic               flip;
      logic signed [15:0] axial;
   } item_type;

   // Clamp to the signed 32-bit range
   function automatic logic signed [31:0] csp_sat(input logic signed [38:0] v);
      logic signed [31:0] r;
      if (v > 39'sd2147483647)
         r = 32'sh7FFFFFFF;
      else if (v < -39'sd2147483648)
         r = 32'sh80000000;
      else
         r = v[31:0];
      return r;
   endfunction

endpackage

// ===== src/csp_front.sv =====
`timescale 1ns / 1ps
module csp_front
   import csp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_payload,
   output logic     push,
   output item_type push_item,
   input  logic     queue_full
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic [1:0]  quad;
   logic [31:0] phase_raw;

   // Classify: quadrants two and three turn by half a turn
   always_comb begin
      quad            = req_payload.angle_turns[15:14];
      phase_raw       = {req_payload.angle_turns, 16'h0000};
      item_in.flip    = (quad == 2'd1) || (quad == 2'd2);
      item_in.phase   = item_in.flip ? $signed(phase_raw - 32'h80000000)
                                     : $signed(phase_raw);
      item_in.axial   = req_payload.axial_position;
   end

   assign req_stall = valid_ff && queue_full;
   assign push      = valid_ff && !queue_full;
   assign push_item = item_ff;
   assign valid_in  = req_stall ? valid_ff : req_valid;

   // Hold while the queue is full
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff <= item_in;
      end
   end

endmodule

// ===== src/csp_queue.sv =====
`timescale 1ns / 1ps
module csp_queue
   import csp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output logic     full,
   output logic     not_empty,
   output item_type head_item
);

   localparam int PW = $clog2(CSP_FIFO_DEPTH);
   localparam int CW = $clog2(CSP_FIFO_DEPTH + 1);

   item_type        mem [0:CSP_FIFO_DEPTH-1];
   logic [PW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]   cnt_ff, cnt_in;

   assign full      = (cnt_ff == CW'(CSP_FIFO_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head_item = mem[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop)
         cnt_in = cnt_ff + 1'b1;
      else if (pop && !push)
         cnt_in = cnt_ff - 1'b1;
   end

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push)
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

`include "cylinder_surface_point_macros.svh"

   `CSP_ASSERT_NOW(a_no_push_full, push, !full, "push into full queue")
   `CSP_ASSERT_NOW(a_no_pop_empty, pop, not_empty, "pop from empty queue")
   `CSP_ASSERT_NEXT(a_count_up, push && !pop, cnt_ff == $past(cnt_ff) + 1'b1, "count lost a push")

endmodule

// ===== src/csp_back.sv =====
`timescale 1ns / 1ps
module csp_back
   import csp_pkg::*;
#(
   parameter int CORDIC_STAGES = CSP_CORDIC_STAGES
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     head_valid,
   input  item_type head_item,
   output logic     pop,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_payload
);

   localparam int N = CORDIC_STAGES;

   logic adv;

   logic signed [CSP_XW-1:0] x_ff [0:N];
   logic signed [CSP_XW-1:0] y_ff [0:N];
   logic signed [CSP_XW-1:0] z_ff [0:N];
   logic signed [CSP_XW-1:0] dx_w [0:N-1];
   logic signed [CSP_XW-1:0] dy_w [0:N-1];
   logic                     flip_ff [0:N];
   logic signed [15:0]       t_ff [0:N];
   logic [N:0]               v_ff;

   logic [3:0]               post_v_ff;
   logic signed [63:0]       pc_ff, ps_ff;
   logic signed [47:0]       pt_ff;
   logic signed [CSP_XW-1:0] cs_in, sn_in;
   logic signed [63:0]       rcs_in, rss_in;
   logic signed [47:0]       tls_in;
   logic signed [CSP_XW-1:0] rc_ff, rs_ff, tl_ff;
   logic signed [34:0]       ax_ff, ay_ff, az_ff, ax2_ff, ay2_ff, az2_ff;
   logic signed [50:0]       mcx_ff, msy_ff, msx_ff, mcy_ff;
   logic signed [52:0]       sx_in, sy_in;
   rsp_type                  out_ff, out_in;
   logic                     out_valid_ff;

   // Whole pipeline moves unless the output is held
   assign adv         = !out_valid_ff || !rsp_stall;
   assign pop         = adv && head_valid;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   always_comb begin
      for (int k = 0; k < N; k++) begin
         dx_w[k] = y_ff[k] >>> k;
         dy_w[k] = x_ff[k] >>> k;
      end
   end

   // Valid shift line through the CORDIC and product stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         post_v_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         v_ff         <= {v_ff[N-1:0], head_valid};
         post_v_ff    <= {post_v_ff[2:0], v_ff[N]};
         out_valid_ff <= post_v_ff[3];
      end
   end

   // CORDIC rotation stages
   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff[0]    <= CSP_CORDIC_K;
         y_ff[0]    <= '0;
         z_ff[0]    <= CSP_XW'(head_item.phase);
         flip_ff[0] <= head_item.flip;
         t_ff[0]    <= head_item.axial;
         for (int k = 0; k < N; k++) begin
            if (!z_ff[k][CSP_XW-1]) begin
               x_ff[k+1] <= x_ff[k] - dx_w[k];
               y_ff[k+1] <= y_ff[k] + dy_w[k];
               z_ff[k+1] <= z_ff[k] - CSP_ATAN[k];
            end else begin
               x_ff[k+1] <= x_ff[k] + dx_w[k];
               y_ff[k+1] <= y_ff[k] - dy_w[k];
               z_ff[k+1] <= z_ff[k] + CSP_ATAN[k];
            end
            flip_ff[k+1] <= flip_ff[k];
            t_ff[k+1]    <= t_ff[k];
         end
      end
   end

   always_comb begin
      cs_in  = flip_ff[N] ? -x_ff[N] : x_ff[N];
      sn_in  = flip_ff[N] ? -y_ff[N] : y_ff[N];
      rcs_in = pc_ff + 64'sd536870912;
      rss_in = ps_ff + 64'sd536870912;
      tls_in = pt_ff + 48'sd8192;
      sx_in  = 53'(mcx_ff) - 53'(msy_ff) + 53'sd8192;
      sy_in  = 53'(msx_ff) + 53'(mcy_ff) + 53'sd8192;
      if (cfg.axis_mode) begin
         out_in.pos_x = csp_sat(sx_in[52:14]);
         out_in.pos_y = csp_sat(sy_in[52:14]);
      end else begin
         out_in.pos_x = csp_sat(39'(ax2_ff));
         out_in.pos_y = csp_sat(39'(ay2_ff));
      end
      out_in.pos_z = csp_sat(39'(az2_ff));
   end

   // Scale, translate, rotate, saturate
   always_ff @(posedge clock) begin
      if (adv) begin
         pc_ff  <= 64'($signed({1'b0, cfg.radius})) * 64'($signed(cs_in[31:0]));
         ps_ff  <= 64'($signed({1'b0, cfg.radius})) * 64'($signed(sn_in[31:0]));
         pt_ff  <= 48'(t_ff[N]) * 48'($signed({1'b0, cfg.axial_length}));
         rc_ff  <= rcs_in[63:30];
         rs_ff  <= rss_in[63:30];
         tl_ff  <= tls_in[47:14];
         if (cfg.axis_mode) begin
            ax_ff <= 35'(cfg.center_x) + 35'(tl_ff);
            ay_ff <= 35'(cfg.center_y) + 35'(rc_ff);
            az_ff <= 35'(cfg.center_z) + 35'(rs_ff);
         end else begin
            ax_ff <= 35'(cfg.center_x) + 35'(rc_ff);
            ay_ff <= 35'(cfg.center_y) + 35'(rs_ff);
            az_ff <= 35'(cfg.center_z) + 35'(tl_ff);
         end
         mcx_ff <= 51'(cfg.rot_cos) * 51'(ax_ff);
         msy_ff <= 51'(cfg.rot_sin) * 51'(ay_ff);
         msx_ff <= 51'(cfg.rot_sin) * 51'(ax_ff);
         mcy_ff <= 51'(cfg.rot_cos) * 51'(ay_ff);
         ax2_ff <= ax_ff;
         ay2_ff <= ay_ff;
         az2_ff <= az_ff;
         out_ff <= out_in;
      end
   end

endmodule

// ===== src/cylinder_surface_point.sv =====
`timescale 1ns / 1ps
// Cylinder surface point generator.
// req channel: angle_turns (65536 = one turn) and axial_position (Q2.14);
// rsp channel: pos_x, pos_y, pos_z in Q16.16, saturated. One response per
// request, in request order. Both channels use valid/stall.
// Throughput: one request per cycle while rsp_stall is low. Between
// request accept and response valid lie the input register, the queue,
// the CORDIC stage line, four scale/translate/rotate stages and the
// output register.
// The front registers and classifies requests into a four-entry queue; the
// back pipeline pulls from it. When rsp_stall is high with a response
// waiting, the back pipeline holds; the queue then fills and req_stall
// rises once it is full.
// Reset (synchronous) empties the pipeline and queue and loads register
// defaults: center 0, radius 1.0, axial length 1.0, rotation identity,
// vertical axis. Write the csr port only while idle; the block won't check.
module cylinder_surface_point
   import csp_pkg::*;
#(
   parameter int CORDIC_STAGES = CSP_CORDIC_STAGES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_payload,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cfg_type  cfg_ff;
   logic     push, pop, queue_full, head_valid;
   item_type push_item, head_item;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_x     <= '0;
         cfg_ff.center_y     <= '0;
         cfg_ff.center_z     <= '0;
         cfg_ff.radius       <= 31'd65536;
         cfg_ff.axial_length <= 31'd65536;
         cfg_ff.rot_cos      <= 16'sd16384;
         cfg_ff.rot_sin      <= '0;
         cfg_ff.axis_mode    <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_CENTER_X:     cfg_ff.center_x     <= $signed(csr_wdata);
            CSR_CENTER_Y:     cfg_ff.center_y     <= $signed(csr_wdata);
            CSR_CENTER_Z:     cfg_ff.center_z     <= $signed(csr_wdata);
            CSR_RADIUS:       cfg_ff.radius       <= csr_wdata[30:0];
            CSR_AXIAL_LENGTH: cfg_ff.axial_length <= csr_wdata[30:0];
            CSR_ROT_COS:      cfg_ff.rot_cos      <= $signed(csr_wdata[15:0]);
            CSR_ROT_SIN:      cfg_ff.rot_sin      <= $signed(csr_wdata[15:0]);
            CSR_AXIS_MODE:    cfg_ff.axis_mode    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   csp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .push        (push),
      .push_item   (push_item),
      .queue_full  (queue_full)
   );

   csp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (head_valid),
      .head_item (head_item)
   );

   csp_back #(
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .head_valid  (head_valid),
      .head_item   (head_item),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== tb/sv/tb_cylinder_surface_point.sv =====
`timescale 1ns / 1ps
module tb_cylinder_surface_point;
   import csp_pkg::*;

   localparam int RANDOM_POINTS = 1900;
   localparam int CALM_TAIL     = 200;
   localparam int SETTLE_CYCLES = CSP_CORDIC_STAGES + 16;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   cylinder_surface_point uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #5 clock = ~clock;

   // shadow of the shell registers
   cfg_type shell;
   rsp_type expected_points[$];
   int      mismatch_count = 0;
   bit      stall_enable = 1'b0;

   // directed rows: register set, request, and a typed z where it is obvious
   typedef struct {
      int          set;
      logic [15:0] angle;
      logic [15:0] axial;
      bit          z_known;
      logic [31:0] z;
   } point_row_type;

   localparam int NUM_ROWS = 22;
   point_row_type rows [NUM_ROWS] = '{
      '{0, 16'h0000, 16'h4000, 1'b1, 32'h0001_0000},
      '{0, 16'h4000, 16'hC000, 1'b1, 32'hFFFF_0000},
      '{0, 16'h8000, 16'h0000, 1'b1, 32'h0000_0000},
      '{0, 16'hC000, 16'h2000, 1'b1, 32'h0000_8000},
      '{0, 16'hFFFF, 16'h7FFF, 1'b0, 32'h0},
      '{0, 16'h3FFF, 16'h8000, 1'b0, 32'h0},
      '{0, 16'h7FFF, 16'h5555, 1'b0, 32'h0},
      '{0, 16'h8001, 16'hAAAA, 1'b0, 32'h0},
      '{0, 16'hBFFF, 16'h0001, 1'b0, 32'h0},
      '{0, 16'h5555, 16'hFFFF, 1'b0, 32'h0},
      '{1, 16'h0000, 16'h8000, 1'b1, 32'h8000_0000},
      '{1, 16'h0000, 16'h4000, 1'b1, 32'hFFFF_FFFF},
      '{1, 16'h4000, 16'h7FFF, 1'b0, 32'h0},
      '{1, 16'h8000, 16'hC000, 1'b1, 32'h8000_0000},
      '{1, 16'hC000, 16'h0000, 1'b1, 32'h8000_0000},
      '{2, 16'h0000, 16'h4000, 1'b0, 32'h0},
      '{2, 16'h4000, 16'hC000, 1'b0, 32'h0},
      '{2, 16'hAAAA, 16'h8000, 1'b0, 32'h0},
      '{2, 16'hFFFF, 16'h7FFF, 1'b0, 32'h0},
      '{3, 16'h2000, 16'h4000, 1'b0, 32'h0},
      '{3, 16'hE000, 16'h8000, 1'b0, 32'h0},
      '{3, 16'h6000, 16'h3FFF, 1'b0, 32'h0}
   };

   // register sets used by the directed rows
   function automatic cfg_type directed_shell(input int set);
      cfg_type c;
      c = '{center_x: 32'sd0, center_y: 32'sd0, center_z: 32'sd0,
            radius: 31'd65536, axial_length: 31'd65536,
            rot_cos: 16'sd16384, rot_sin: 16'sd0, axis_mode: 1'b0};
      case (set)
         1: begin
            c.center_x = 32'h7FFF_FFFF; c.center_y = 32'h8000_0000;
            c.center_z = 32'h8000_0000; c.radius = 31'h7FFF_FFFF;
            c.axial_length = 31'h7FFF_FFFF;
         end
         2: begin
            c.center_x = 32'h7FFF_FFFF; c.center_y = 32'h8000_0000;
            c.center_z = 32'h7FFF_FFFF; c.radius = 31'h7FFF_FFFF;
            c.axial_length = 31'h7FFF_FFFF; c.rot_cos = -16'sd16384;
            c.rot_sin = 16'sd16384; c.axis_mode = 1'b1;
         end
         3: begin
            c.center_x = 32'h0012_3456; c.center_y = 32'hFFF0_0000;
            c.center_z = 32'h0000_1000; c.radius = 31'h0003_0000;
            c.axial_length = 31'h0000_0000; c.rot_cos = 16'sh7FFF;
            c.rot_sin = 16'sh8000; c.axis_mode = 1'b1;
         end
         default: ;
      endcase
      return c;
   endfunction

   function automatic logic [31:0] pick32(input logic [31:0] lo, input logic [31:0] hi);
      case ($urandom_range(0, 5))
         0: return lo;
         1: return hi;
         2: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] pick_q14();
      case ($urandom_range(0, 7))
         0: return 16'h4000;
         1: return 16'hC000;
         2: return 16'($urandom);
         default: return 16'(int'($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   function automatic cfg_type random_shell();
      cfg_type c;
      c.center_x = pick32(32'h8000_0000, 32'h7FFF_FFFF);
      c.center_y = pick32(32'h8000_0000, 32'h7FFF_FFFF);
      c.center_z = pick32(32'h8000_0000, 32'h7FFF_FFFF);
      c.radius = 31'(pick32(32'h0, 32'h7FFF_FFFF));
      c.axial_length = 31'(pick32(32'h0, 32'h7FFF_FFFF));
      c.rot_cos = pick_q14();
      c.rot_sin = pick_q14();
      c.axis_mode = 1'($urandom_range(0, 1));
      return c;
   endfunction

   // round half up, then floor shift
   function automatic longint round_shift(input longint p, input int s);
      return (p + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic logic [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647)
         return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648)
         return 32'h8000_0000;
      return v[31:0];
   endfunction

   // CORDIC sine and cosine in Q2.30 with half-turn folding
   function automatic void turn_sincos(input logic [15:0] angle,
                                       output longint cosine, output longint sine);
      logic [31:0] phase;
      bit          fold;
      longint      x, y, z, dx, dy;
      phase = {angle, 16'h0000};
      fold = (angle[15:14] == 2'd1) || (angle[15:14] == 2'd2);
      if (fold)
         phase = phase - 32'h8000_0000;
      z = longint'($signed(phase));
      x = longint'(CSP_CORDIC_K);
      y = 0;
      for (int i = 0; i < CSP_CORDIC_STAGES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - longint'(CSP_ATAN[i]);
         end else begin
            x = x + dx; y = y - dy; z = z + longint'(CSP_ATAN[i]);
         end
      end
      cosine = fold ? -x : x;
      sine = fold ? -y : y;
   endfunction

   function automatic rsp_type surface_point(input req_type r);
      rsp_type p;
      longint  cs, sn, rc, rs, tl, x0, y0, cx, cy, cz, rcos, rsin;
      turn_sincos(r.angle_turns, cs, sn);
      cx = longint'(shell.center_x);
      cy = longint'(shell.center_y);
      cz = longint'(shell.center_z);
      rcos = longint'(shell.rot_cos);
      rsin = longint'(shell.rot_sin);
      rc = round_shift(longint'({1'b0, shell.radius}) * cs, 30);
      rs = round_shift(longint'({1'b0, shell.radius}) * sn, 30);
      tl = round_shift(longint'(r.axial_position) * longint'({1'b0, shell.axial_length}), 14);
      if (!shell.axis_mode) begin
         p.pos_x = clamp32(cx + rc);
         p.pos_y = clamp32(cy + rs);
         p.pos_z = clamp32(cz + tl);
      end else begin
         x0 = cx + tl;
         y0 = cy + rc;
         p.pos_x = clamp32(round_shift(rcos * x0 - rsin * y0, 14));
         p.pos_y = clamp32(round_shift(rsin * x0 + rcos * y0, 14));
         p.pos_z = clamp32(cz + rs);
      end
      return p;
   endfunction

   task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %08h expected %08h at %0t", field, got, want, $realtime);
      mismatch_count++;
   endtask

   // check each accepted point against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_points.size() == 0) begin
            report("unexpected point", rsp_payload.pos_x, 32'h0);
         end else begin
            want = expected_points.pop_front();
            if (rsp_payload.pos_x !== want.pos_x) report("pos_x", rsp_payload.pos_x, want.pos_x);
            if (rsp_payload.pos_y !== want.pos_y) report("pos_y", rsp_payload.pos_y, want.pos_y);
            if (rsp_payload.pos_z !== want.pos_z) report("pos_z", rsp_payload.pos_z, want.pos_z);
         end
      end
   end

   // stall the result side in random bursts
   initial begin
      forever begin
         if (stall_enable && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
      end
   end

   task automatic write_csr(input csr_index_type idx, input logic [31:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // drop the request, wait for the pipeline to empty, then load every register
   task automatic load_shell(input cfg_type c);
      req_valid <= 1'b0;
      wait (expected_points.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_csr(CSR_CENTER_X, c.center_x);
      write_csr(CSR_CENTER_Y, c.center_y);
      write_csr(CSR_CENTER_Z, c.center_z);
      write_csr(CSR_RADIUS, {1'b0, c.radius});
      write_csr(CSR_AXIAL_LENGTH, {1'b0, c.axial_length});
      write_csr(CSR_ROT_COS, {16'h0, c.rot_cos});
      write_csr(CSR_ROT_SIN, {16'h0, c.rot_sin});
      write_csr(CSR_AXIS_MODE, {31'h0, c.axis_mode});
      csr_wr_en <= 1'b0;
      shell = c;
   endtask

   // send one request and hold it until accepted
   task automatic send_request(input req_type r, input bit z_known, input logic [31:0] z);
      rsp_type want;
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      want = surface_point(r);
      if (z_known)
         want.pos_z = z;
      expected_points.push_back(want);
   endtask

   task automatic sender_gap(input bit allow);
      if (allow && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   initial begin
      req_type r;
      int      cur_set;
      shell = directed_shell(0);
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows; set 0 is the reset state and needs no write
      cur_set = 0;
      for (int i = 0; i < NUM_ROWS; i++) begin
         if (rows[i].set != cur_set) begin
            cur_set = rows[i].set;
            load_shell(directed_shell(cur_set));
         end
         r.angle_turns = rows[i].angle;
         r.axial_position = rows[i].axial;
         send_request(r, rows[i].z_known, rows[i].z);
      end

      // random points with occasional register changes
      stall_enable = 1'b1;
      for (int n = 0; n < RANDOM_POINTS; n++) begin
         if (n == RANDOM_POINTS - CALM_TAIL)
            stall_enable = 1'b0;
         if (n % 150 == 0)
            load_shell(random_shell());
         else if (n == 700) begin
            req_valid <= 1'b0;
            wait (expected_points.size() == 0);
            @(posedge clock);
         end
         r.angle_turns = 16'($urandom);
         if ($urandom_range(0, 9) == 0)
            r.axial_position = 16'($urandom);
         else
            r.axial_position = 16'(int'($urandom_range(0, 32768)) - 16384);
         send_request(r, 1'b0, 32'h0);
         sender_gap(n < RANDOM_POINTS - CALM_TAIL);
      end
      req_valid <= 1'b0;

      // drain and finish
      wait (expected_points.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // hang guard
   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/csp_pkg.sv
src/csp_front.sv
src/csp_queue.sv
src/csp_back.sv
src/cylinder_surface_point.sv
tb/sv/tb_cylinder_surface_point.sv
